FILE: hw/rtl/ctsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsu_pkg
// Shared constants, types and tables of the circular trajectory setpoint unit.
// ----------------------------------------------------------------------------
package ctsu_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int FRAC_BITS    = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam int XY_W   = 45;  // CORDIC x/y, holds normalised vectors below 2^41
   localparam int Z_W    = 34;  // CORDIC angle, Q30
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DIVD_W = 54;
   localparam int DIVS_W = 32;
   localparam int DIVC_W = $clog2(DIVD_W);

   localparam longint INV2PI_Q32  = 64'sd683565276;
   localparam longint TWOPI_Q29   = 64'sd3373259426;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint PI_Q28      = 64'sd843314857;
   localparam longint PI_HALF_Q30 = 64'sd1686629714;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint NORM_LIMIT  = 64'sd1099511627776;
   localparam longint DUR_LIMIT   = 64'sd1000 << FRAC_BITS;
   localparam longint INT32_MAX   = 64'sd2147483647;
   localparam longint INT32_MIN   = -64'sd2147483648;

   typedef enum logic [2:0] {
      REG_START_TIME  = 3'd0,
      REG_CENTER_X    = 3'd1,
      REG_CENTER_Y    = 3'd2,
      REG_CENTER_Z    = 3'd3,
      REG_RADIUS      = 3'd4,
      REG_START_ANGLE = 3'd5,
      REG_TURN_ANGLE  = 3'd6,
      REG_DURATION    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                   start;
      logic                   vector_mode;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_cmd_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] r;
      begin
         case (i)
            0: r = Z_W'(843314856);
            1: r = Z_W'(497837829);
            2: r = Z_W'(263043836);
            3: r = Z_W'(133525158);
            4: r = Z_W'(67021686);
            5: r = Z_W'(33543515);
            6: r = Z_W'(16775850);
            7: r = Z_W'(8388437);
            8: r = Z_W'(4194282);
            9: r = Z_W'(2097149);
            default: begin
               if (int'(i) < 30) r = Z_W'((64'sd1 <<< (30 - int'(i))) - 64'sd1);
               else r = '0;
            end
         endcase
         return r;
      end
   endfunction

endpackage

FILE: hw/rtl/ctsu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsu_req_if / ctsu_rsp_if
// Valid/ready channels carrying time requests and setpoint responses.
// ----------------------------------------------------------------------------
interface ctsu_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] now;

   modport source (output valid, output now, input ready);
   modport sink (input valid, input now, output ready);
endinterface

interface ctsu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [30:0] heading;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_z;
   logic               pose_valid;
   logic               finished;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output heading,
                   output quat_w, output quat_z, output pose_valid, output finished,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, input heading,
                 input quat_w, input quat_z, input pose_valid, input finished,
                 output ready);
endinterface

FILE: hw/rtl/circular_trajectory_setpoint_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_trajectory_setpoint_unit
// Setpoint generator on a horizontal circle with heading toward the centre.
// ----------------------------------------------------------------------------
// Usage:
//  req carries one absolute time per beat; rsp returns one setpoint beat per
//  request: position, heading, yaw quaternion, pose_valid and finished.
//  csr_* writes the eight registers (index 0 origin time .. 7 duration); any
//  write drops the latched angular rate. Write only while the block is idle.
//  The first request with a valid duration latches the rate through the
//  restoring divider, which lengthens that request.
//  A request runs three 24-step CORDIC passes (position, heading,
//  quaternion) on one shared unit, plus up to 40 doublings of the heading
//  vector, the rest of the work on one shared 33x33 multiplier. A setpoint
//  on the centre skips the heading pass. Without a latched rate and with
//  an invalid duration the request goes from the check straight to the
//  response register.
//  req.ready is high only while the sequencer is idle, so the next request
//  is taken at the earliest in the cycle after the response register loads. A
//  finished response is held in the output register while rsp.ready is low;
//  a new request may be accepted meanwhile and waits at the end of its sequence.
//  Reset (synchronous) clears the configuration, the state, the response valid flag and the latched rate.
// ----------------------------------------------------------------------------
module circular_trajectory_setpoint_unit (
   input  logic              clock,
   input  logic              reset,
   ctsu_req_if.sink          req,
   ctsu_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [47:0]       csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_RMUL, S_RDIV0, S_RDIV, S_SPH, S_M0, S_M1, S_M2, S_M3,
      S_FOLD, S_AMUL, S_ANG, S_ROT1, S_PXM, S_PYM, S_PY, S_PYC, S_DIF, S_NORM,
      S_QUAD, S_VEC, S_HEAD, S_QSTART, S_ROT2, S_OUT
   } state_type;

   localparam int XW = ctsu_pkg::XY_W;
   localparam int ZW = ctsu_pkg::Z_W;
   localparam int MW = ctsu_pkg::MUL_W;

   state_type state_ff;

   // configuration
   logic [47:0]        t_origin_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff, turn_ff;
   logic [30:0]        radius_ff;
   logic signed [30:0] start_ang_ff;
   logic [31:0]        dur_ff;
   logic               rate_ready_ff;
   logic [47:0]        rate_ff;

   // working registers
   logic [48:0]          elapsed_ff;
   logic                 finished_ff, pv_ff, flip_ff, vneg_ff;
   logic [47:0]          acc_ff;
   logic [30:0]          vm_ff;
   logic signed [31:0]   c_ff, s_ff, px_ff, py_ff, qw_ff, qz_ff;
   logic signed [32:0]   tx_ff, ty_ff;
   logic signed [XW-1:0] vx_ff, vy_ff;
   logic signed [ZW-1:0] zvec_ff;
   logic signed [30:0]   h_ff;
   logic signed [ctsu_pkg::PROD_W-1:0] prod_ff, mul_prod_in;

   // response register
   logic               rsp_valid_ff, rsp_pv_ff, rsp_fin_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_qw_ff, rsp_qz_ff;
   logic signed [30:0] rsp_h_ff;

   logic signed [MW-1:0] mul_a, mul_b;
   logic [31:0]          turn_mag;
   logic [30:0]          smag;
   logic                 dur_ok;
   logic [47:0]          sph;
   logic signed [32:0]   fold_v, fold_w;
   logic                 fold_flip;
   logic [30:0]          fold_m;
   logic [ctsu_pkg::PROD_W-1:0] ang_sum;
   logic signed [ZW-1:0] ang_z, hsum, hs, hw;
   logic signed [ctsu_pkg::PROD_W-1:0] rnd_sum;
   logic signed [33:0]   sum_x, sum_y;
   logic                 vsmall;

   ctsu_pkg::cordic_cmd_type cmd;
   logic                     cor_done;
   logic signed [XW-1:0]     cor_x, cor_y;
   logic signed [ZW-1:0]     cor_z;
   logic                     div_start, div_done;
   logic [ctsu_pkg::DIVD_W-1:0] div_q;

   ctsu_cordic u_cordic (
      .clock (clock), .reset (reset), .cmd (cmd), .done (cor_done),
      .x_out (cor_x), .y_out (cor_y), .z_out (cor_z)
   );

   ctsu_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (prod_ff[61:8]), .divisor (dur_ff),
      .done (div_done), .quotient (div_q)
   );

   function automatic logic signed [31:0] clamp_q30(input logic signed [XW-1:0] v);
      logic signed [31:0] r;
      begin
         if (v > ctsu_pkg::ONE_Q30) r = 32'(ctsu_pkg::ONE_Q30);
         else if (v < -ctsu_pkg::ONE_Q30) r = 32'(-ctsu_pkg::ONE_Q30);
         else r = 32'(v);
         return r;
      end
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
      logic signed [31:0] r;
      begin
         if (v > ctsu_pkg::INT32_MAX) r = 32'(ctsu_pkg::INT32_MAX);
         else if (v < ctsu_pkg::INT32_MIN) r = 32'(ctsu_pkg::INT32_MIN);
         else r = 32'(v);
         return r;
      end
   endfunction

   always_comb begin
      turn_mag = turn_ff[31] ? 32'(-turn_ff) : 32'(turn_ff);
      smag     = start_ang_ff[30] ? 31'(-start_ang_ff) : 31'(start_ang_ff);
      dur_ok   = (dur_ff != '0) && ({32'b0, dur_ff} < 64'(ctsu_pkg::DUR_LIMIT));
      sph      = prod_ff[59:12];

      // fold the phase into a quarter turn either side of zero
      fold_v    = {acc_ff[47], acc_ff[47:16]};
      fold_flip = 1'b0;
      fold_w    = fold_v;
      if (fold_v > ctsu_pkg::ONE_Q30) begin
         fold_w    = fold_v - 33'sd2147483648;
         fold_flip = 1'b1;
      end else if (fold_v < -ctsu_pkg::ONE_Q30) begin
         fold_w    = fold_v + 33'sd2147483648;
         fold_flip = 1'b1;
      end
      fold_m = fold_w[32] ? 31'(-fold_w) : 31'(fold_w);

      ang_sum = prod_ff + (66'd1 << 30);
      ang_z   = vneg_ff ? -$signed({2'b00, ang_sum[62:31]}) : $signed({2'b00, ang_sum[62:31]});

      rnd_sum = prod_ff + (66'sd1 <<< 29);
      sum_x   = 34'(tx_ff) + 34'(cx_ff);
      sum_y   = 34'(ty_ff) + 34'(cy_ff);

      vsmall = (vx_ff < ctsu_pkg::NORM_LIMIT) && (vx_ff > -ctsu_pkg::NORM_LIMIT) &&
               (vy_ff < ctsu_pkg::NORM_LIMIT) && (vy_ff > -ctsu_pkg::NORM_LIMIT);

      hsum = zvec_ff + ZW'(2);
      hs   = hsum >>> 2;
      if (hs <= -ctsu_pkg::PI_Q28) hw = hs + ZW'(2 * ctsu_pkg::PI_Q28);
      else if (hs > ctsu_pkg::PI_Q28) hw = hs - ZW'(2 * ctsu_pkg::PI_Q28);
      else hw = hs;
   end

   // shared multiplier operand select; product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_RMUL: begin
            mul_a = $signed({1'b0, turn_mag});
            mul_b = MW'(ctsu_pkg::INV2PI_Q32);
         end
         S_SPH: begin
            mul_a = $signed({2'b00, smag});
            mul_b = MW'(ctsu_pkg::INV2PI_Q32);
         end
         S_M0: begin
            mul_a = $signed({9'b0, elapsed_ff[23:0]});
            mul_b = $signed({9'b0, rate_ff[23:0]});
         end
         S_M1: begin
            mul_a = $signed({9'b0, elapsed_ff[47:24]});
            mul_b = $signed({9'b0, rate_ff[23:0]});
         end
         S_M2: begin
            mul_a = $signed({9'b0, elapsed_ff[23:0]});
            mul_b = $signed({9'b0, rate_ff[47:24]});
         end
         S_AMUL: begin
            mul_a = $signed({2'b00, vm_ff});
            mul_b = MW'(ctsu_pkg::TWOPI_Q29);
         end
         S_PXM: begin
            mul_a = $signed({2'b00, radius_ff});
            mul_b = MW'(c_ff);
         end
         S_PYM: begin
            mul_a = $signed({2'b00, radius_ff});
            mul_b = MW'(s_ff);
         end
         default: ;
      endcase
      mul_prod_in = mul_a * mul_b;
   end

   always_comb begin
      cmd             = '0;
      div_start       = (state_ff == S_RDIV0);
      case (state_ff)
         S_ANG: begin
            cmd.start = 1'b1;
            cmd.x     = XW'(ctsu_pkg::GAIN_Q30);
            cmd.z     = ang_z;
         end
         S_QUAD: begin
            cmd.start       = 1'b1;
            cmd.vector_mode = 1'b1;
            cmd.x           = vx_ff;
            cmd.y           = vy_ff;
            if (vx_ff < 0) begin
               if (vy_ff >= 0) begin
                  cmd.x = vy_ff;
                  cmd.y = -vx_ff;
                  cmd.z = ZW'(ctsu_pkg::PI_HALF_Q30);
               end else begin
                  cmd.x = -vy_ff;
                  cmd.y = vx_ff;
                  cmd.z = ZW'(-ctsu_pkg::PI_HALF_Q30);
               end
            end
         end
         S_QSTART: begin
            cmd.start = 1'b1;
            cmd.x     = XW'(ctsu_pkg::GAIN_Q30);
            cmd.z     = $signed({{(ZW - 32){h_ff[30]}}, h_ff, 1'b0});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_prod_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         rate_ready_ff <= 1'b0;
         rate_ff       <= '0;
         t_origin_ff   <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         cz_ff         <= '0;
         radius_ff     <= '0;
         start_ang_ff  <= '0;
         turn_ff       <= '0;
         dur_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            rate_ready_ff <= 1'b0;
            rate_ff       <= '0;
            case (ctsu_pkg::csr_index_type'(csr_index))
               ctsu_pkg::REG_START_TIME:  t_origin_ff   <= csr_data;
               ctsu_pkg::REG_CENTER_X:    cx_ff         <= csr_data[31:0];
               ctsu_pkg::REG_CENTER_Y:    cy_ff         <= csr_data[31:0];
               ctsu_pkg::REG_CENTER_Z:    cz_ff         <= csr_data[31:0];
               ctsu_pkg::REG_RADIUS:      radius_ff     <= csr_data[30:0];
               ctsu_pkg::REG_START_ANGLE: start_ang_ff  <= csr_data[30:0];
               ctsu_pkg::REG_TURN_ANGLE:  turn_ff       <= csr_data[31:0];
               ctsu_pkg::REG_DURATION:    dur_ff        <= csr_data[31:0];
               default: ;
            endcase
         end

         // S_OUT reloads the response register itself
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  elapsed_ff <= {1'b0, req.now} - {1'b0, t_origin_ff};
                  state_ff   <= S_CHK;
               end
            end
            S_CHK: begin
               finished_ff <= $signed(elapsed_ff) >= $signed({17'b0, dur_ff});
               pv_ff       <= rate_ready_ff || dur_ok;
               if (!rate_ready_ff && dur_ok) state_ff <= S_RMUL;
               else if (rate_ready_ff) state_ff <= S_SPH;
               else state_ff <= S_OUT;
            end
            S_RMUL: state_ff <= S_RDIV0;
            S_RDIV0: state_ff <= S_RDIV;
            S_RDIV: begin
               if (div_done) begin
                  rate_ff       <= turn_ff[31] ? -div_q[47:0] : div_q[47:0];
                  rate_ready_ff <= 1'b1;
                  state_ff      <= S_SPH;
               end
            end
            S_SPH: state_ff <= S_M0;
            S_M0: begin
               acc_ff   <= start_ang_ff[30] ? -sph : sph;
               state_ff <= S_M1;
            end
            S_M1: begin
               acc_ff   <= acc_ff + prod_ff[47:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= acc_ff + {prod_ff[23:0], 24'b0};
               state_ff <= S_M3;
            end
            S_M3: begin
               acc_ff   <= acc_ff + {prod_ff[23:0], 24'b0};
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               vm_ff    <= fold_m;
               vneg_ff  <= fold_w[32];
               flip_ff  <= fold_flip;
               state_ff <= S_AMUL;
            end
            S_AMUL: state_ff <= S_ANG;
            S_ANG: state_ff <= S_ROT1;
            S_ROT1: begin
               if (cor_done) begin
                  c_ff     <= flip_ff ? -clamp_q30(cor_x) : clamp_q30(cor_x);
                  s_ff     <= flip_ff ? -clamp_q30(cor_y) : clamp_q30(cor_y);
                  state_ff <= S_PXM;
               end
            end
            S_PXM: state_ff <= S_PYM;
            S_PYM: begin
               tx_ff    <= rnd_sum[62:30];
               state_ff <= S_PY;
            end
            S_PY: begin
               ty_ff    <= rnd_sum[62:30];
               px_ff    <= clamp32(sum_x);
               state_ff <= S_PYC;
            end
            S_PYC: begin
               py_ff    <= clamp32(sum_y);
               state_ff <= S_DIF;
            end
            S_DIF: begin
               vx_ff    <= XW'(33'(cx_ff) - 33'(px_ff));
               vy_ff    <= XW'(33'(cy_ff) - 33'(py_ff));
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (vx_ff == '0 && vy_ff == '0) begin
                  zvec_ff  <= '0;
                  state_ff <= S_HEAD;
               end else if (vsmall) begin
                  vx_ff <= vx_ff <<< 1;
                  vy_ff <= vy_ff <<< 1;
               end else begin
                  state_ff <= S_QUAD;
               end
            end
            S_QUAD: state_ff <= S_VEC;
            S_VEC: begin
               if (cor_done) begin
                  zvec_ff  <= cor_z;
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               h_ff     <= hw[30:0];
               state_ff <= S_QSTART;
            end
            S_QSTART: state_ff <= S_ROT2;
            S_ROT2: begin
               if (cor_done) begin
                  qw_ff    <= clamp_q30(cor_x);
                  qz_ff    <= clamp_q30(cor_y);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_fin_ff   <= finished_ff;
                  rsp_pv_ff    <= pv_ff;
                  rsp_x_ff     <= pv_ff ? px_ff : '0;
                  rsp_y_ff     <= pv_ff ? py_ff : '0;
                  rsp_z_ff     <= pv_ff ? cz_ff : '0;
                  rsp_h_ff     <= pv_ff ? h_ff : '0;
                  rsp_qw_ff    <= pv_ff ? qw_ff : '0;
                  rsp_qz_ff    <= pv_ff ? qz_ff : '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pos_x      = rsp_x_ff;
   assign rsp.pos_y      = rsp_y_ff;
   assign rsp.pos_z      = rsp_z_ff;
   assign rsp.heading    = rsp_h_ff;
   assign rsp.quat_w     = rsp_qw_ff;
   assign rsp.quat_z     = rsp_qz_ff;
   assign rsp.pose_valid = rsp_pv_ff;
   assign rsp.finished   = rsp_fin_ff;

endmodule

FILE: hw/rtl/ctsu_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsu_cordic
// Shared CORDIC unit, one iteration per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module ctsu_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  ctsu_pkg::cordic_cmd_type       cmd,
   output logic                           done,
   output logic signed [ctsu_pkg::XY_W-1:0] x_out,
   output logic signed [ctsu_pkg::XY_W-1:0] y_out,
   output logic signed [ctsu_pkg::Z_W-1:0]  z_out
);

   logic signed [ctsu_pkg::XY_W-1:0] x_ff, y_ff, sx, sy;
   logic signed [ctsu_pkg::Z_W-1:0]  z_ff, a;
   logic [ctsu_pkg::STEP_W-1:0]      cnt_ff;
   logic                             busy_ff, vec_ff, done_ff, neg, last_step;

   always_comb begin
      sx  = y_ff >>> cnt_ff;
      sy  = x_ff >>> cnt_ff;
      a   = ctsu_pkg::atan_q30(cnt_ff);
      // rotation drives z to zero, vectoring drives y to zero
      neg = vec_ff ? (y_ff <= 0) : (z_ff >= 0);
      last_step = (cnt_ff == ctsu_pkg::STEP_W'(ctsu_pkg::CORDIC_STEPS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (cmd.start) begin
         x_ff    <= cmd.x;
         y_ff    <= cmd.y;
         z_ff    <= cmd.z;
         vec_ff  <= cmd.vector_mode;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (neg) begin
            x_ff <= x_ff - sx;
            y_ff <= y_ff + sy;
            z_ff <= z_ff - a;
         end else begin
            x_ff <= x_ff + sx;
            y_ff <= y_ff - sy;
            z_ff <= z_ff + a;
         end
         if (last_step) busy_ff <= 1'b0;
         done_ff <= last_step;
         cnt_ff  <= cnt_ff + 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

FILE: hw/rtl/ctsu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctsu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ctsu_pkg::DIVD_W-1:0]   dividend,
   input  logic [ctsu_pkg::DIVS_W-1:0]   divisor,
   output logic                          done,
   output logic [ctsu_pkg::DIVD_W-1:0]   quotient
);

   logic [ctsu_pkg::DIVD_W-1:0] rq_ff;
   logic [ctsu_pkg::DIVS_W-1:0] rem_ff, dsr_ff;
   logic [ctsu_pkg::DIVC_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff, ge, last_step;
   logic [ctsu_pkg::DIVS_W:0]   trial, diff;

   always_comb begin
      trial     = {rem_ff, rq_ff[ctsu_pkg::DIVD_W-1]};
      ge        = trial >= {1'b0, dsr_ff};
      diff      = trial - {1'b0, dsr_ff};
      last_step = (cnt_ff == ctsu_pkg::DIVC_W'(ctsu_pkg::DIVD_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         rq_ff   <= dividend;
         dsr_ff  <= divisor;
         rem_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[ctsu_pkg::DIVS_W-1:0] : trial[ctsu_pkg::DIVS_W-1:0];
         rq_ff  <= {rq_ff[ctsu_pkg::DIVD_W-2:0], ge};
         if (last_step) busy_ff <= 1'b0;
         done_ff <= last_step;
         cnt_ff  <= cnt_ff + 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = rq_ff;

endmodule

FILE: tb/ctsu_setpoint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsu_setpoint_checker
// Watches the request, response and register ports of the circular trajectory
// setpoint unit. It keeps its own copy of the registers and of the latched
// rate, works out each setpoint in fixed point and compares the responses
// against it, in order and field by field.
// ----------------------------------------------------------------------------
module ctsu_setpoint_checker
   import ctsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ctsu_req_if         req,
   ctsu_rsp_if         rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output int          pending,
   output int          errors,
   output int          beats_checked,
   output int          valid_poses
);

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [30:0] heading;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_z;
      logic               pose_valid;
      logic               finished;
   } setpoint_t;

   setpoint_t setpoint_q[$];

   // register shadow and latched rate
   logic [47:0]        t_start;
   logic signed [31:0] cen_x, cen_y, cen_z;
   logic [30:0]        rad;
   logic signed [30:0] ang0;
   logic signed [31:0] sweep;
   logic [31:0]        dur;
   logic               rate_held;
   logic [47:0]        rate_turns;

   localparam longint PHASE_MASK = 64'hFFFF_FFFF_FFFF;

   function automatic longint arctan_step(input int i);
      longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return head[i];
      if (i < 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic sincos_q30(input longint za, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = GAIN_Q30;
      y = 0;
      z = za;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      c = clip(x, -ONE_Q30, ONE_Q30);
      s = clip(y, -ONE_Q30, ONE_Q30);
   endtask

   function automatic longint bearing_q30(input longint xi, input longint yi);
      longint x, y, z, m, t, dx, dy;
      x = xi;
      y = yi;
      z = 0;
      m = (x < 0 ? -x : x);
      if ((y < 0 ? -y : y) > m) m = (y < 0 ? -y : y);
      if (m == 0) return 0;
      while (m < NORM_LIMIT) begin
         x *= 2; y *= 2; m *= 2;
      end
      // pre-rotate the left half-plane by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = PI_HALF_Q30;
         end else begin
            t = x; x = -y; y = t; z = -PI_HALF_Q30;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_step(i);
         end else begin
            x -= dx; y += dy; z -= arctan_step(i);
         end
      end
      return z;
   endfunction

   task automatic predict_setpoint(input logic [47:0] now, output setpoint_t sp);
      longint            elapsed, v, vm, ang, c, s, px, py, h, qw, qz;
      longint unsigned   mag, q, sph, dt, ph, u;
      logic              flip;
      sp = '0;
      elapsed = longint'({16'd0, now}) - longint'({16'd0, t_start});
      sp.finished = elapsed >= longint'({32'd0, dur});
      if (!rate_held && dur > 0 && longint'({32'd0, dur}) < DUR_LIMIT) begin
         mag = sweep < 0 ? -longint'(sweep) : longint'(sweep);
         q = (mag * INV2PI_Q32) / ({32'd0, dur} << 8);
         if (sweep < 0) q = -q;
         rate_turns = q[47:0];
         rate_held = 1'b1;
      end
      if (rate_held) begin
         mag = ang0 < 0 ? -longint'(ang0) : longint'(ang0);
         sph = (mag * INV2PI_Q32) >> 12;
         if (ang0 < 0) sph = -sph;
         dt = ({16'd0, now} - {16'd0, t_start}) & PHASE_MASK;
         ph = (sph + dt * {16'd0, rate_turns}) & PHASE_MASK;
         u = ph >> 16;
         v = longint'(signed'(u[31:0]));
         flip = 1'b0;
         if (v > (64'sd1 <<< 30)) begin
            v -= 64'sd1 <<< 31; flip = 1'b1;
         end else if (v < -(64'sd1 <<< 30)) begin
            v += 64'sd1 <<< 31; flip = 1'b1;
         end
         vm = v < 0 ? -v : v;
         ang = (vm * TWOPI_Q29 + (64'sd1 <<< 30)) >>> 31;
         if (v < 0) ang = -ang;
         sincos_q30(ang, c, s);
         if (flip) begin
            c = -c; s = -s;
         end
         px = ((longint'(rad) * c + (64'sd1 <<< 29)) >>> 30) + cen_x;
         py = ((longint'(rad) * s + (64'sd1 <<< 29)) >>> 30) + cen_y;
         px = clip(px, INT32_MIN, INT32_MAX);
         py = clip(py, INT32_MIN, INT32_MAX);
         h = (bearing_q30(cen_x - px, cen_y - py) + 2) >>> 2;
         if (h <= -PI_Q28) h += 2 * PI_Q28;
         else if (h > PI_Q28) h -= 2 * PI_Q28;
         sincos_q30(2 * h, qw, qz);
         sp.pos_x      = 32'(px);
         sp.pos_y      = 32'(py);
         sp.pos_z      = cen_z;
         sp.heading    = 31'(h);
         sp.quat_w     = 32'(qw);
         sp.quat_z     = 32'(qz);
         sp.pose_valid = 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      setpoint_t sp, got;
      if (reset) begin
         t_start = '0; cen_x = '0; cen_y = '0; cen_z = '0;
         rad = '0; ang0 = '0; sweep = '0; dur = '0;
         rate_held = 1'b0; rate_turns = '0;
         setpoint_q.delete();
         errors = 0; beats_checked = 0; valid_poses = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               REG_START_TIME:  t_start = csr_data;
               REG_CENTER_X:    cen_x   = csr_data[31:0];
               REG_CENTER_Y:    cen_y   = csr_data[31:0];
               REG_CENTER_Z:    cen_z   = csr_data[31:0];
               REG_RADIUS:      rad     = csr_data[30:0];
               REG_START_ANGLE: ang0    = csr_data[30:0];
               REG_TURN_ANGLE:  sweep   = csr_data[31:0];
               REG_DURATION:    dur     = csr_data[31:0];
            endcase
            rate_held = 1'b0;
            rate_turns = '0;
         end
         if (req.valid && req.ready) begin
            predict_setpoint(req.now, sp);
            setpoint_q.push_back(sp);
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.heading, rsp.quat_w,
                    rsp.quat_z, rsp.pose_valid, rsp.finished};
            if (setpoint_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errors++;
            end else begin
               sp = setpoint_q.pop_front();
               compare_field("pos_x", sp.pos_x, got.pos_x);
               compare_field("pos_y", sp.pos_y, got.pos_y);
               compare_field("pos_z", sp.pos_z, got.pos_z);
               compare_field("heading", sp.heading, got.heading);
               compare_field("quat_w", sp.quat_w, got.quat_w);
               compare_field("quat_z", sp.quat_z, got.quat_z);
               compare_field("pose_valid", sp.pose_valid, got.pose_valid);
               compare_field("finished", sp.finished, got.finished);
               beats_checked++;
               if (sp.pose_valid) valid_poses++;
            end
         end
      end
      pending = setpoint_q.size();
   end

endmodule

FILE: tb/tb_circular_trajectory_setpoint_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_trajectory_setpoint_unit
// Drives time requests and register settings into the setpoint unit with
// random gaps and response back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_circular_trajectory_setpoint_unit;
   import ctsu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;
   int          pending, errors, beats_checked, valid_poses;
   int          sent = 0;
   int          phases = 0;
   logic        rsp_hold_on = 1'b1;

   ctsu_req_if req ();
   ctsu_rsp_if rsp ();

   circular_trajectory_setpoint_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ctsu_setpoint_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending       (pending),
      .errors        (errors),
      .beats_checked (beats_checked),
      .valid_poses   (valid_poses)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30ms;
      $display("FAIL circular_trajectory_setpoint_unit");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // response back-pressure; switched off now and then for stall-free stretches
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_on) begin
            rsp.ready = 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
         rsp.ready = 1'b1;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [47:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_time(input logic [47:0] t, input logic gaps);
      int g;
      @(negedge clock);
      req.valid = 1'b1;
      req.now   = t;
      do @(posedge clock); while (!req.ready);
      sent++;
      g = gaps ? pick_gap() : 0;
      if (g > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_trajectory(input logic [47:0] t0, input logic [31:0] cx,
                                  input logic [31:0] cy, input logic [31:0] cz,
                                  input logic [30:0] r, input logic [30:0] a0,
                                  input logic [31:0] turn, input logic [31:0] d);
      wait_drained();
      phases++;
      csr_write(REG_START_TIME, t0);
      csr_write(REG_CENTER_X, {16'd0, cx});
      csr_write(REG_CENTER_Y, {16'd0, cy});
      csr_write(REG_CENTER_Z, {16'd0, cz});
      csr_write(REG_RADIUS, {17'd0, r});
      csr_write(REG_START_ANGLE, {17'd0, a0});
      csr_write(REG_TURN_ANGLE, {16'd0, turn});
      csr_write(REG_DURATION, {16'd0, d});
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   initial begin
      logic [47:0] t0, t;
      logic [31:0] d, cx, cy;
      logic [30:0] r;
      longint      off;
      int          n;
      req.valid = 1'b0;
      req.now   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers at reset: duration zero, no pose, finished high
      send_time(48'd0, 1'b0);
      send_time(48'hFFFF_FFFF_FFFF, 1'b0);
      // duration of exactly 1000 s is rejected
      load_trajectory(48'd1000, 32'd65536, 32'd0, 32'd0, 31'd65536, 31'd0,
                      32'd26353589, 32'd65536000);
      send_time(48'd0, 1'b0);
      send_time(48'd70000000, 1'b0);
      // zero radius: setpoint sits on the centre, heading zero
      load_trajectory(48'd0, 32'd123456, -32'sd98765, 32'd5, 31'd0, 31'd0,
                      32'd26353589, 32'd655360);
      send_time(48'd0, 1'b0);
      send_time(48'd327680, 1'b0);
      // shortest duration, extreme centre and radius, negative sweep
      load_trajectory(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      31'h7FFF_FFFF, 31'sd843314857, 32'h8000_0000, 32'd1);
      send_time(48'hFFFF_FFFF_FFFF, 1'b0);
      send_time(48'd0, 1'b0);
      send_time(48'hFFFF_FFFF_FFFE, 1'b0);
      // longest valid duration, start angle at minus pi, time before start
      load_trajectory(48'd10000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      31'd1000000, -31'sd843314857, 32'h7FFF_FFFF, 32'd65535999);
      send_time(48'd0, 1'b0);
      send_time(48'd9999999, 1'b0);
      send_time(48'd10000000, 1'b0);
      send_time(48'd75535999, 1'b0);
      send_time(48'd75536000, 1'b0);
      // start angle beyond pi is wrapped, quarter-turn sweep
      load_trajectory(48'd0, 32'd0, 32'd0, 32'd0, 31'd655360, 31'sd1000000000,
                      32'd26353589, 32'd655360);
      for (int i = 0; i <= 8; i++) send_time(48'(i * 81920), 1'b0);

      while (sent < 1150) begin
         t0 = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom);
         case ($urandom_range(0, 9))
            0:       d = 32'd0;
            1:       d = 32'd65536000 + $urandom_range(0, 1000000);
            2:       d = $urandom;
            3:       d = $urandom_range(1, 64);
            default: d = $urandom_range(1, 65535999);
         endcase
         r  = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
         cx = ($urandom_range(0, 5) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
         cy = ($urandom_range(0, 5) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
         load_trajectory(t0, cx, cy, $urandom, r,
                         31'($signed($urandom_range(0, 1686629714)) - 843314857),
                         $urandom, d);
         rsp_hold_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(10, 60);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               t = rand48();
            end else begin
               off = longint'($urandom_range(0, 1300)) * longint'(d) / 1000
                     - longint'($urandom_range(0, 2)) * longint'(d) / 20;
               t = t0 + 48'(off);
            end
            send_time(t, 1'b1);
            if (i == n / 2 && $urandom_range(0, 4) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Run covered %0d requests over %0d register settings, %0d responses checked",
               sent, phases, beats_checked);
      $display("  of which %0d carried a valid pose", valid_poses);
      if (errors == 0 && pending == 0) begin
         $display("PASS circular_trajectory_setpoint_unit");
      end else begin
         $display("FAIL circular_trajectory_setpoint_unit");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ctsu_pkg.sv
hw/rtl/ctsu_if.sv
hw/rtl/ctsu_cordic.sv
hw/rtl/ctsu_div.sv
hw/rtl/circular_trajectory_setpoint_unit.sv
tb/ctsu_setpoint_checker.sv
tb/tb_circular_trajectory_setpoint_unit.sv
